FILE: rtl/core/best_fit_chunk_allocator_macros.svh
// Assertion macros used by the chunk allocator top level.
`ifndef BEST_FIT_CHUNK_ALLOCATOR_MACROS_SVH
`define BEST_FIT_CHUNK_ALLOCATOR_MACROS_SVH

`ifndef SYNTHESIS
`define BFCA_ASSERT_ALWAYS(name, clk, rst_n, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define BFCA_ASSERT_NEXT(name, clk, rst_n, trig, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error(msg);
`else
`define BFCA_ASSERT_ALWAYS(name, clk, rst_n, cond, msg)
`define BFCA_ASSERT_NEXT(name, clk, rst_n, trig, cond, msg)
`endif

`endif

FILE: rtl/core/bfca_pkg.sv
// Shared types and constants of the best-fit chunk allocator.
package bfca_pkg;

  localparam int unsigned FREE_SLOTS_DEF = 64;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_CHUNK_SIZE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PRELOAD   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_ARCHIVE = 2'd2;

  localparam logic [31:0] CHUNK_SIZE_RST    = 32'd209715200;
  localparam logic [15:0] MAX_PRELOAD_RST   = 16'd1024;
  localparam logic [14:0] FIRST_ARCHIVE_RST = 15'd0;
  localparam logic [14:0] ARCHIVE_TOP       = 15'd32766;

  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef struct packed {
    logic [31:0] offset;
    logic [31:0] length;
    logic [14:0] archive;
  } list_entry_t;

  typedef struct packed {
    logic [15:0] preload_taken;
    logic [31:0] stored_length;
  } preload_t;

  typedef struct packed {
    logic        in_directory;
    logic [14:0] archive_num;
    logic [31:0] offset;
    logic        reused;
    logic [15:0] preload_taken;
    logic [31:0] stored_length;
    logic        status;
  } result_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

endpackage

FILE: rtl/core/bfca_in_if.sv
// Input channel of the chunk allocator: valid/ready plus the request beat.
interface bfca_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [31:0] data_length;
  logic        to_directory;
  logic [31:0] preload_request;
  logic [31:0] release_offset;
  logic [31:0] release_length;
  logic [14:0] release_archive;

  modport source (
    output valid, op, data_length, to_directory, preload_request,
           release_offset, release_length, release_archive,
    input  ready
  );
  modport sink (
    input  valid, op, data_length, to_directory, preload_request,
           release_offset, release_length, release_archive,
    output ready
  );
endinterface

FILE: rtl/core/bfca_out_if.sv
// Result channel of the chunk allocator: valid/ready plus the result beat.
interface bfca_out_if;
  logic        valid;
  logic        ready;
  logic        in_directory;
  logic [14:0] archive_num;
  logic [31:0] offset;
  logic        reused;
  logic [15:0] preload_taken;
  logic [31:0] stored_length;
  logic        status;

  modport source (
    output valid, in_directory, archive_num, offset, reused, preload_taken,
           stored_length, status,
    input  ready
  );
  modport sink (
    input  valid, in_directory, archive_num, offset, reused, preload_taken,
           stored_length, status,
    output ready
  );
endinterface

FILE: rtl/core/bfca_preload_calc.sv
// Preload clamp and stored length of an allocate request.
module bfca_preload_calc (
  input  logic [31:0]        data_length,
  input  logic [31:0]        preload_request,
  input  logic [15:0]        max_preload,
  output bfca_pkg::preload_t res
);
  import bfca_pkg::*;

  logic [15:0] lim;
  logic [15:0] pre;

  always_comb begin
    lim = (data_length > {16'b0, max_preload}) ? max_preload : data_length[15:0];
    if (preload_request == 32'd0) begin
      pre = 16'd0;
    end else if (preload_request > {16'b0, lim}) begin
      pre = lim;
    end else begin
      pre = preload_request[15:0];
    end
    res.preload_taken = pre;
    res.stored_length = data_length - {16'b0, pre};
  end
endmodule

FILE: rtl/core/bfca_list_mem.sv
// Free-list storage: one write port, one registered read port.
module bfca_list_mem #(
  parameter int unsigned DEPTH  = bfca_pkg::FREE_SLOTS_DEF,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic                  clk,
  input  bfca_pkg::mem_ctl_t    ctl,
  input  logic [ADDR_W-1:0]     rd_addr,
  output bfca_pkg::list_entry_t rd_data,
  input  logic [ADDR_W-1:0]     wr_addr,
  input  bfca_pkg::list_entry_t wr_data
);
  import bfca_pkg::*;

  list_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule

FILE: rtl/core/best_fit_chunk_allocator.sv
// Best-fit chunk allocator top level: request sequencer around the free-list memory.
// One request is handled at a time. A release, a directory item or an allocate
// against an empty free list goes from accept straight to the done state, which
// loads the result register. An allocate against a list of N entries scans the
// list through the single read port of the free-list memory and on a hit closes
// the gap left by the taken entry with one read and one write per cycle before
// the result is loaded. A new request can be accepted while the previous result
// still waits on the output. There is no clearing pass after reset; the list
// count alone marks which entries hold data.
`include "best_fit_chunk_allocator_macros.svh"

module best_fit_chunk_allocator #(
  parameter int unsigned FREE_SLOTS = bfca_pkg::FREE_SLOTS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  bfca_in_if.sink                            in_if,
  bfca_out_if.source                         out_if,
  input  logic                               cfg_we,
  input  logic [bfca_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bfca_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import bfca_pkg::*;

  localparam int unsigned ADDR_W = $clog2(FREE_SLOTS);
  localparam int unsigned CNT_W  = $clog2(FREE_SLOTS + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_COMP = 3'd2;
  localparam logic [2:0] ST_DONE = 3'd3;

  logic [2:0]        state_r, state_nxt;
  logic [31:0]       chunk_size_r, chunk_size_nxt;
  logic [15:0]       max_preload_r, max_preload_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [14:0]       arc_ctr_r, arc_ctr_nxt;
  logic [32:0]       fill_r, fill_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic              rv_r, rv_nxt;
  logic              found_r, found_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic [ADDR_W-1:0] rtag_r, rtag_nxt;
  logic [ADDR_W-1:0] best_r, best_nxt;
  logic [31:0]       gap_r, gap_nxt;
  logic [31:0]       best_off_r, best_off_nxt;
  logic [14:0]       best_arc_r, best_arc_nxt;
  logic [31:0]       len_r, len_nxt;
  preload_t          pre_r, pre_nxt;
  result_t           res_r, res_nxt;
  result_t           out_r, out_nxt;

  mem_ctl_t          mem_ctl;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  list_entry_t       rd_data;
  list_entry_t       wr_data;

  preload_t          pre_calc;
  logic              in_fire;
  logic [31:0]       app_stored;
  logic [32:0]       fill_sum;
  logic [31:0]       cand_gap;

  bfca_preload_calc u_preload (
    .data_length     (in_if.data_length),
    .preload_request (in_if.preload_request),
    .max_preload     (max_preload_r),
    .res             (pre_calc)
  );

  bfca_list_mem #(
    .DEPTH  (FREE_SLOTS),
    .ADDR_W (ADDR_W)
  ) u_list_mem (
    .clk     (clk),
    .ctl     (mem_ctl),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  assign in_if.ready = (state_r == ST_IDLE);
  assign in_fire     = in_if.valid && in_if.ready;

  assign app_stored = (state_r == ST_IDLE) ? pre_calc.stored_length : pre_r.stored_length;
  assign fill_sum   = fill_r + {1'b0, app_stored};
  assign cand_gap   = rd_data.length - len_r;

  always_comb begin
    state_nxt       = state_r;
    chunk_size_nxt  = chunk_size_r;
    max_preload_nxt = max_preload_r;
    count_nxt       = count_r;
    arc_ctr_nxt     = arc_ctr_r;
    fill_nxt        = fill_r;
    idx_nxt         = idx_r;
    rv_nxt          = 1'b0;
    found_nxt       = found_r;
    out_valid_nxt   = out_valid_r;
    rtag_nxt        = rtag_r;
    best_nxt        = best_r;
    gap_nxt         = gap_r;
    best_off_nxt    = best_off_r;
    best_arc_nxt    = best_arc_r;
    len_nxt         = len_r;
    pre_nxt         = pre_r;
    res_nxt         = res_r;
    out_nxt         = out_r;
    mem_ctl         = '0;
    rd_addr         = '0;
    wr_addr         = '0;
    wr_data         = '0;

    if (out_valid_r && out_if.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          len_nxt   = in_if.data_length;
          pre_nxt   = pre_calc;
          res_nxt   = '0;
          found_nxt = 1'b0;
          idx_nxt   = '0;
          state_nxt = ST_DONE;
          if (in_if.op == OP_RELEASE) begin
            if (count_r == CNT_W'(FREE_SLOTS)) begin
              res_nxt.status = STATUS_FULL;
            end else begin
              mem_ctl.wr_en = 1'b1;
              wr_addr       = count_r[ADDR_W-1:0];
              wr_data       = '{offset:  in_if.release_offset,
                                length:  in_if.release_length,
                                archive: in_if.release_archive};
              count_nxt     = count_r + CNT_W'(1);
            end
          end else begin
            res_nxt.preload_taken = pre_calc.preload_taken;
            res_nxt.stored_length = pre_calc.stored_length;
            if (in_if.to_directory) begin
              res_nxt.in_directory = 1'b1;
            end else if (count_r == '0) begin
              res_nxt.archive_num = arc_ctr_r;
              res_nxt.offset      = fill_r[31:0];
              if (fill_sum > {1'b0, chunk_size_r}) begin
                fill_nxt = '0;
                if (arc_ctr_r < ARCHIVE_TOP) begin
                  arc_ctr_nxt = arc_ctr_r + 15'd1;
                end
              end else begin
                fill_nxt = fill_sum;
              end
            end else begin
              state_nxt = ST_SCAN;
            end
          end
        end
      end

      ST_SCAN: begin
        if (idx_r < count_r) begin
          mem_ctl.rd_en = 1'b1;
          rd_addr       = idx_r[ADDR_W-1:0];
          rv_nxt        = 1'b1;
          rtag_nxt      = idx_r[ADDR_W-1:0];
          idx_nxt       = idx_r + CNT_W'(1);
        end
        if (rv_r && (rd_data.length >= len_r)) begin
          if (!found_r || (cand_gap < gap_r)) begin
            found_nxt    = 1'b1;
            best_nxt     = rtag_r;
            gap_nxt      = cand_gap;
            best_off_nxt = rd_data.offset;
            best_arc_nxt = rd_data.archive;
          end
        end
        if ((idx_r == count_r) && !rv_r) begin
          res_nxt.archive_num = arc_ctr_r;
          if (found_r) begin
            res_nxt.reused      = 1'b1;
            res_nxt.offset      = best_off_r;
            res_nxt.archive_num = best_arc_r;
            idx_nxt             = CNT_W'(best_r) + CNT_W'(1);
            state_nxt           = ST_COMP;
          end else begin
            res_nxt.offset = fill_r[31:0];
            if (fill_sum > {1'b0, chunk_size_r}) begin
              fill_nxt = '0;
              if (arc_ctr_r < ARCHIVE_TOP) begin
                arc_ctr_nxt = arc_ctr_r + 15'd1;
              end
            end else begin
              fill_nxt = fill_sum;
            end
            state_nxt = ST_DONE;
          end
        end
      end

      ST_COMP: begin
        if (idx_r < count_r) begin
          mem_ctl.rd_en = 1'b1;
          rd_addr       = idx_r[ADDR_W-1:0];
          rv_nxt        = 1'b1;
          rtag_nxt      = idx_r[ADDR_W-1:0];
          idx_nxt       = idx_r + CNT_W'(1);
        end
        if (rv_r) begin
          mem_ctl.wr_en = 1'b1;
          wr_addr       = rtag_r - ADDR_W'(1);
          wr_data       = rd_data;
        end else if (idx_r >= count_r) begin
          // remainder goes where the last entry was before the removal
          if (gap_r != 32'd0) begin
            mem_ctl.wr_en = 1'b1;
            wr_addr       = count_r[ADDR_W-1:0] - ADDR_W'(1);
            wr_data       = '{offset:  best_off_r + len_r,
                              length:  gap_r,
                              archive: best_arc_r};
          end else begin
            count_nxt = count_r - CNT_W'(1);
          end
          state_nxt = ST_DONE;
        end
      end

      ST_DONE: begin
        if (!out_valid_r || out_if.ready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (cfg_we) begin
      unique case (cfg_index)
        REG_CHUNK_SIZE:    chunk_size_nxt  = cfg_data[31:0];
        REG_MAX_PRELOAD:   max_preload_nxt = cfg_data[15:0];
        REG_FIRST_ARCHIVE: arc_ctr_nxt     = cfg_data[14:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      chunk_size_r  <= CHUNK_SIZE_RST;
      max_preload_r <= MAX_PRELOAD_RST;
      count_r       <= '0;
      arc_ctr_r     <= FIRST_ARCHIVE_RST;
      fill_r        <= '0;
      idx_r         <= '0;
      rv_r          <= 1'b0;
      found_r       <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      chunk_size_r  <= chunk_size_nxt;
      max_preload_r <= max_preload_nxt;
      count_r       <= count_nxt;
      arc_ctr_r     <= arc_ctr_nxt;
      fill_r        <= fill_nxt;
      idx_r         <= idx_nxt;
      rv_r          <= rv_nxt;
      found_r       <= found_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rtag_r     <= rtag_nxt;
    best_r     <= best_nxt;
    gap_r      <= gap_nxt;
    best_off_r <= best_off_nxt;
    best_arc_r <= best_arc_nxt;
    len_r      <= len_nxt;
    pre_r      <= pre_nxt;
    res_r      <= res_nxt;
    out_r      <= out_nxt;
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.in_directory  = out_r.in_directory;
  assign out_if.archive_num   = out_r.archive_num;
  assign out_if.offset        = out_r.offset;
  assign out_if.reused        = out_r.reused;
  assign out_if.preload_taken = out_r.preload_taken;
  assign out_if.stored_length = out_r.stored_length;
  assign out_if.status        = out_r.status;

  `BFCA_ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_r <= CNT_W'(FREE_SLOTS), "free list count past capacity")
  `BFCA_ASSERT_ALWAYS(a_wr_in_list, clk, rst_n, !mem_ctl.wr_en || (CNT_W'(wr_addr) <= count_r), "list write beyond the list end")
  `BFCA_ASSERT_ALWAYS(a_fill_bound, clk, rst_n, fill_r[32] == 1'b0, "fill level overflowed 32 bits")
  `BFCA_ASSERT_NEXT(a_one_item, clk, rst_n, in_if.valid && in_if.ready, !in_if.ready, "second beat taken while busy")

endmodule

FILE: bench/testbench.sv
// Self-checking bench for the best-fit chunk allocator: random and directed beats vs a local model.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bfca_pkg::*;

  localparam int SLOTS = FREE_SLOTS_DEF;

  typedef struct packed {
    logic        op;
    logic [31:0] len;
    logic        dir;
    logic [31:0] pre;
    logic [31:0] roff;
    logic [31:0] rlen;
    logic [14:0] rarc;
  } chunk_req_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  bfca_in_if  in_if();
  bfca_out_if out_if();

  best_fit_chunk_allocator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .out_if    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // free list and fill state of the model
  logic [31:0] free_off [SLOTS];
  logic [31:0] free_len [SLOTS];
  logic [14:0] free_arc [SLOTS];
  int          free_count;
  logic [14:0] arc_counter;
  logic [33:0] fill;
  logic [31:0] chunk_limit;
  logic [15:0] preload_cap;

  chunk_req_t pending_reqs[$];
  result_t    expected_placements[$];
  chunk_req_t offered;
  int         n_in_beats;
  int         send_gap_pct;
  int         recv_gap_pct;
  int         hold_left;
  logic       hold_done;
  int         errors = 0;

  always #4 clk = ~clk;

  task automatic report(input string msg);
    errors++;
    $display("ERROR at %0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) report($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  task automatic queue_req(input chunk_req_t r);
    pending_reqs = {pending_reqs, r};
  endtask

  task automatic free_push(input logic [31:0] o, input logic [31:0] l, input logic [14:0] a);
    free_off[free_count] = o;
    free_len[free_count] = l;
    free_arc[free_count] = a;
    free_count++;
  endtask

  task automatic predict_placement(input chunk_req_t r, output result_t res);
    int          best;
    bit          hit;
    logic [31:0] gap;
    logic [31:0] g;
    logic [31:0] lim;
    logic [15:0] pre;
    res = '0;
    hit = 1'b0;
    best = 0;
    gap = '0;
    pre = '0;
    if (r.op == OP_RELEASE) begin
      if (free_count >= SLOTS) res.status = STATUS_FULL;
      else free_push(r.roff, r.rlen, r.rarc);
    end else begin
      if (r.dir) begin
        res.in_directory = 1'b1;
      end else begin
        res.archive_num = arc_counter;
        for (int i = 0; i < free_count; i++) begin
          if (free_len[i] >= r.len) begin
            g = free_len[i] - r.len;
            if (!hit || g < gap) begin
              hit = 1'b1;
              best = i;
              gap = g;
            end
          end
        end
        if (hit) begin
          res.reused = 1'b1;
          res.offset = free_off[best];
          res.archive_num = free_arc[best];
          for (int i = best; i < free_count - 1; i++) begin
            free_off[i] = free_off[i + 1];
            free_len[i] = free_len[i + 1];
            free_arc[i] = free_arc[i + 1];
          end
          free_count--;
          if (gap != 0) free_push(res.offset + r.len, gap, res.archive_num);
        end
      end
      if (r.pre != 0) begin
        lim = (r.len > {16'd0, preload_cap}) ? {16'd0, preload_cap} : r.len;
        pre = (r.pre > lim) ? lim[15:0] : r.pre[15:0];
      end
      res.preload_taken = pre;
      res.stored_length = r.len - {16'd0, pre};
      if (!r.dir && !hit) begin
        res.offset = fill[31:0];
        fill = fill + {2'b00, res.stored_length};
        if (fill > {2'b00, chunk_limit}) begin
          fill = '0;
          if (arc_counter < ARCHIVE_TOP) arc_counter++;
        end
      end
    end
  endtask

  // driver: offers queued beats, mirrors register writes and predicts each accepted beat
  always @(posedge clk) begin : drive_requests
    result_t res;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      n_in_beats <= 0;
      free_count = 0;
      arc_counter = FIRST_ARCHIVE_RST;
      fill = '0;
      chunk_limit = CHUNK_SIZE_RST;
      preload_cap = MAX_PRELOAD_RST;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_CHUNK_SIZE:    chunk_limit = cfg_data;
          REG_MAX_PRELOAD:   preload_cap = cfg_data[15:0];
          REG_FIRST_ARCHIVE: arc_counter = cfg_data[14:0];
          default: ;
        endcase
      end
      if (in_if.valid && in_if.ready) begin
        predict_placement(offered, res);
        expected_placements = {expected_placements, res};
        n_in_beats <= n_in_beats + 1;
      end
      if (!in_if.valid || in_if.ready) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          offered = pending_reqs.pop_front();
          in_if.valid           <= 1'b1;
          in_if.op              <= offered.op;
          in_if.data_length     <= offered.len;
          in_if.to_directory    <= offered.dir;
          in_if.preload_request <= offered.pre;
          in_if.release_offset  <= offered.roff;
          in_if.release_length  <= offered.rlen;
          in_if.release_archive <= offered.rarc;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off once the run is well under way
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && n_in_beats >= 100) begin
      hold_left <= 400;
      hold_done <= 1'b1;
    end
  end

  // monitor: compares each result beat with the oldest predicted placement
  always @(posedge clk) begin : check_results
    result_t got;
    result_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        got = {out_if.in_directory, out_if.archive_num, out_if.offset, out_if.reused,
               out_if.preload_taken, out_if.stored_length, out_if.status};
        if (expected_placements.size() == 0) begin
          report("result beat with no placement expected");
        end else begin
          want = expected_placements.pop_front();
          check_field("in_directory", 32'(got.in_directory), 32'(want.in_directory));
          check_field("archive_num", 32'(got.archive_num), 32'(want.archive_num));
          check_field("offset", got.offset, want.offset);
          check_field("reused", 32'(got.reused), 32'(want.reused));
          check_field("preload_taken", 32'(got.preload_taken), 32'(want.preload_taken));
          check_field("stored_length", got.stored_length, want.stored_length);
          check_field("status", 32'(got.status), 32'(want.status));
        end
      end
      out_if.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_gap_pct);
    end
  end

  function automatic chunk_req_t alloc_req(input logic [31:0] len, input logic dir,
                                           input logic [31:0] pre);
    chunk_req_t r;
    r = '0;
    r.op = OP_ALLOC;
    r.len = len;
    r.dir = dir;
    r.pre = pre;
    return r;
  endfunction

  function automatic chunk_req_t release_req(input logic [31:0] o, input logic [31:0] l,
                                             input logic [14:0] a);
    chunk_req_t r;
    r = '0;
    r.op = OP_RELEASE;
    r.roff = o;
    r.rlen = l;
    r.rarc = a;
    return r;
  endfunction

  // lengths on a coarse grid so exact fits and ties turn up often
  function automatic logic [31:0] fit_len();
    logic [31:0] l;
    l = $urandom_range(16) * 64;
    if ($urandom_range(1) != 0) l = l + $urandom_range(63);
    return l;
  endfunction

  function automatic chunk_req_t rand_req(input int rel_pct);
    chunk_req_t r;
    int         pick;
    r.op = ($urandom_range(99) < rel_pct) ? OP_RELEASE : OP_ALLOC;
    r.dir = ($urandom_range(99) < 15);
    pick = $urandom_range(9);
    r.len = (pick == 0) ? $urandom() : (pick == 1) ? 32'd0 : fit_len();
    pick = $urandom_range(9);
    r.pre = (pick < 3) ? 32'd0 : (pick < 5) ? $urandom() : $urandom_range(2000);
    r.roff = $urandom();
    r.rlen = ($urandom_range(9) == 0) ? $urandom() : fit_len();
    r.rarc = 15'($urandom_range(32767));
    return r;
  endfunction

  task automatic wait_quiet();
    @(negedge clk);
    while (pending_reqs.size() != 0 || in_if.valid || expected_placements.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input logic [31:0] chunk, input logic [31:0] cap,
                           input logic [31:0] first, input int rel_pct,
                           input int send_pct, input int recv_pct);
    write_reg(REG_CHUNK_SIZE, chunk);
    write_reg(REG_MAX_PRELOAD, cap);
    write_reg(REG_FIRST_ARCHIVE, first);
    send_gap_pct <= send_pct;
    recv_gap_pct <= recv_pct;
    @(negedge clk);
    repeat (100) queue_req(rand_req(rel_pct));
    wait_quiet();
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_if.valid = 1'b0;
    in_if.op = OP_ALLOC;
    in_if.data_length = '0;
    in_if.to_directory = 1'b0;
    in_if.preload_request = '0;
    in_if.release_offset = '0;
    in_if.release_length = '0;
    in_if.release_archive = '0;
    out_if.ready = 1'b0;
    send_gap_pct = 10;
    recv_gap_pct = 48;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part on reset register values
    queue_req(alloc_req(32'd0, 1'b0, 32'd0));
    queue_req(alloc_req(32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF));
    queue_req(alloc_req(32'd100, 1'b1, 32'd50));
    queue_req(alloc_req(32'd10, 1'b1, 32'hFFFF_FFFF));
    queue_req(release_req(32'hFFFF_FF00, 32'h200, 15'd32767));
    queue_req(release_req(32'd1000, 32'd300, 15'd5));
    queue_req(release_req(32'd2000, 32'd300, 15'd6));
    queue_req(release_req(32'd3000, 32'd0, 15'd0));
    queue_req(alloc_req(32'd300, 1'b0, 32'd0));
    queue_req(alloc_req(32'd0, 1'b0, 32'd0));
    queue_req(alloc_req(32'h100, 1'b0, 32'd7));
    queue_req(alloc_req(32'h180, 1'b0, 32'd2000));
    queue_req(alloc_req(32'd1000000, 1'b0, 32'd0));
    queue_req(release_req(32'hFFFF_FFFF, 32'hFFFF_FFFF, 15'd0));
    queue_req(alloc_req(32'hFFFF_FFFF, 1'b0, 32'd1));
    queue_req(alloc_req(32'd5, 1'b0, 32'hFFFF_FFFF));
    wait_quiet();

    run_phase(32'd5000, 32'd0, 32'd32764, 70, 10, 48);
    run_phase(32'd0, 32'd65535, 32'd0, 40, 10, 48);
    run_phase(32'hFFFF_FFFF, 32'd1024, 32'd100, 25, 48, 10);
    run_phase($urandom_range(1000000, 1), $urandom_range(65535), $urandom_range(32766),
              50, 48, 10);
    run_phase(32'd200000, 32'd300, 32'd32766, 10, 0, 0);
    run_phase($urandom(), $urandom_range(65535), $urandom_range(32766), 35, 0, 0);

    repeat (300) @(posedge clk);
    if (errors == 0) begin
      $display("PASS best_fit_chunk_allocator");
    end else begin
      $display("FAIL best_fit_chunk_allocator");
    end
    $finish;
  end

  initial begin
    #6_000_000;
    $display("ERROR: timeout");
    $display("FAIL best_fit_chunk_allocator");
    $finish;
  end

endmodule

FILE: best_fit_chunk_allocator.f
+incdir+rtl/core
rtl/core/bfca_pkg.sv
rtl/core/bfca_in_if.sv
rtl/core/bfca_out_if.sv
rtl/core/bfca_preload_calc.sv
rtl/core/bfca_list_mem.sv
rtl/core/best_fit_chunk_allocator.sv
bench/testbench.sv
